@@ sv/ulf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulf_pkg
// Shared types and constants for the UTF-8 validator with Latin-1 fallback.
// ----------------------------------------------------------------------------
package ulf_pkg;

    localparam int QUEUE_DEPTH = 4;

    // One command from the front part: a source byte, sent either as it
    // stands or re-encoded as a Latin-1 pair, and whether it closes the
    // output of its input beat.
    typedef struct packed {
        logic [7:0] data;
        logic       lat;
        logic       last;
    } t_cmd;

endpackage

@@ sv/ulf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulf_front
// Accepts input beats, tracks the pending UTF-8 run and issues one command
// per cycle into the queue while the queue is not full.
// ----------------------------------------------------------------------------
module ulf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    input  logic [7:0]    i_s_data,
    input  logic          i_s_last,
    output logic          o_push,
    output ulf_pkg::t_cmd o_cmd,
    input  logic          i_q_full
);

    // Run state
    logic [7:0] r_lead, n_lead;
    logic [7:0] r_cont0, n_cont0;
    logic [7:0] r_cont1, n_cont1;
    logic [1:0] r_have, n_have;
    logic [1:0] r_need, n_need;

    // Plan of the accepted beat: held bytes first, then optionally the beat
    // byte itself.
    logic [7:0] r_p_lead, r_p_cont0, r_p_cont1, r_p_byte;
    logic [1:0] r_p_hn;
    logic       r_p_hlat;
    logic       r_p_blat;
    logic [2:0] r_rem;
    logic [1:0] r_idx;

    logic       w_accept;
    logic       w_is_cont;
    logic [1:0] w_lead_need;
    logic       w_complete;
    logic [1:0] n_hn;
    logic       n_hlat;
    logic       n_take;
    logic       n_blat;

    always_comb begin
        priority if (!i_s_data[7]) begin
            w_lead_need = 2'd0;
        end else if (i_s_data[7:5] == 3'b110) begin
            w_lead_need = 2'd1;
        end else if (i_s_data[7:4] == 4'b1110) begin
            w_lead_need = 2'd2;
        end else if (i_s_data[7:3] == 5'b11110) begin
            w_lead_need = 2'd3;
        end else begin
            w_lead_need = 2'd0;
        end
    end

    assign w_is_cont  = (i_s_data[7:6] == 2'b10);
    assign w_complete = (({1'b0, r_have} + 3'd1) >= {1'b0, r_need}) || (r_have >= 2'd2);

    always_comb begin
        n_lead  = r_lead;
        n_cont0 = r_cont0;
        n_cont1 = r_cont1;
        n_have  = r_have;
        n_need  = r_need;
        n_hn    = 2'd0;
        n_hlat  = 1'b0;
        n_take  = 1'b0;
        n_blat  = 1'b0;
        if (r_need == 2'd0 || !w_is_cont) begin
            // A broken run is flushed as Latin-1 before the byte is handled.
            if (r_need != 2'd0) begin
                n_hn   = 2'(r_have + 2'd1);
                n_hlat = 1'b1;
                n_lead = 8'd0;
                n_have = 2'd0;
                n_need = 2'd0;
            end
            if (!i_s_data[7]) begin
                n_take = 1'b1;
            end else if (w_lead_need != 2'd0) begin
                if (i_s_last) begin
                    // A lead on the final byte is flushed at once.
                    n_take = 1'b1;
                    n_blat = 1'b1;
                end else begin
                    n_lead = i_s_data;
                    n_have = 2'd0;
                    n_need = w_lead_need;
                end
            end else begin
                n_take = 1'b1;
                n_blat = 1'b1;
            end
        end else if (w_complete) begin
            n_hn   = 2'(r_have + 2'd1);
            n_take = 1'b1;
            n_lead = 8'd0;
            n_have = 2'd0;
            n_need = 2'd0;
        end else if (i_s_last) begin
            n_hn   = 2'(r_have + 2'd1);
            n_hlat = 1'b1;
            n_take = 1'b1;
            n_blat = 1'b1;
            n_lead = 8'd0;
            n_have = 2'd0;
            n_need = 2'd0;
        end else begin
            if (r_have[0]) begin
                n_cont1 = i_s_data;
            end else begin
                n_cont0 = i_s_data;
            end
            n_have = 2'(r_have + 2'd1);
        end
    end

    assign o_push    = (r_rem != 3'd0) && !i_q_full;
    assign o_s_ready = (r_rem == 3'd0) || ((r_rem == 3'd1) && o_push);
    assign w_accept  = i_s_valid && o_s_ready;

    always_comb begin
        o_cmd.last = (r_rem == 3'd1);
        if ({1'b0, r_idx} < {1'b0, r_p_hn}) begin
            o_cmd.lat = r_p_hlat;
            unique case (r_idx)
                2'd0:    o_cmd.data = r_p_lead;
                2'd1:    o_cmd.data = r_p_cont0;
                default: o_cmd.data = r_p_cont1;
            endcase
        end else begin
            o_cmd.lat  = r_p_blat;
            o_cmd.data = r_p_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= 8'd0;
            r_have <= 2'd0;
            r_need <= 2'd0;
            r_rem  <= 3'd0;
            r_idx  <= 2'd0;
        end else begin
            if (w_accept) begin
                r_lead <= n_lead;
                r_have <= n_have;
                r_need <= n_need;
                r_rem  <= {1'b0, n_hn} + {2'b00, n_take};
                r_idx  <= 2'd0;
            end else if (o_push) begin
                r_rem <= r_rem - 3'd1;
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cont0   <= n_cont0;
            r_cont1   <= n_cont1;
            r_p_lead  <= r_lead;
            r_p_cont0 <= r_cont0;
            r_p_cont1 <= r_cont1;
            r_p_byte  <= i_s_data;
            r_p_hn    <= n_hn;
            r_p_hlat  <= n_hlat;
            r_p_blat  <= n_blat;
        end
    end

endmodule

@@ sv/ulf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulf_queue
// Small command queue between the front and back parts.
// ----------------------------------------------------------------------------
module ulf_queue #(
    parameter int DEPTH = ulf_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ulf_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output ulf_pkg::t_cmd o_head,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ulf_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

@@ sv/ulf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulf_back
// Takes commands from the queue and drives output beats, splitting a
// Latin-1 command into its two-byte UTF-8 form.
// ----------------------------------------------------------------------------
module ulf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ulf_pkg::t_cmd i_head,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_m_valid,
    input  logic          i_m_ready,
    output logic [7:0]    o_m_data,
    output logic          o_m_last
);

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;
    logic       r_half;
    logic [5:0] r_lo;
    logic       r_hlast;
    logic       w_load;

    assign w_load    = !r_valid || i_m_ready;
    assign o_pop     = w_load && !r_half && !i_empty;
    assign o_m_valid = r_valid;
    assign o_m_data  = r_data;
    assign o_m_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (w_load) begin
            if (r_half) begin
                r_valid <= 1'b1;
                r_half  <= 1'b0;
            end else if (!i_empty) begin
                r_valid <= 1'b1;
                r_half  <= i_head.lat;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_half) begin
                r_data <= {2'b10, r_lo};
                r_last <= r_hlast;
            end else if (i_head.lat) begin
                // First byte of the pair carries the top two bits.
                r_data  <= {6'b110000, i_head.data[7:6]};
                r_last  <= 1'b0;
                r_lo    <= i_head.data[5:0];
                r_hlast <= i_head.last;
            end else begin
                r_data <= i_head.data;
                r_last <= i_head.last;
            end
        end
    end

endmodule

@@ sv/utf8_validate_latin1_fallback.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_validate_latin1_fallback
// Passes valid UTF-8 runs through and re-encodes stray or broken bytes as
// Latin-1 in two-byte UTF-8 form.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata          tlast
// s_axis   in   in_byte[7:0]   end_of_text
// m_axis   out  out_byte[7:0]  last_of_run
//
// The front part takes one input beat and issues up to four commands, one
// per cycle while the queue is not full; an input beat with one command
// is taken every cycle under that condition. The back part sends one
// output beat per cycle while the output is ready, two for a Latin-1 byte.
// Reset is synchronous and active low and leaves no run pending.
// A stalled output fills the command queue and then holds the input.
// ----------------------------------------------------------------------------
module utf8_validate_latin1_fallback #(
    parameter int QUEUE_DEPTH = ulf_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast
);

    ulf_pkg::t_cmd w_push_cmd;
    ulf_pkg::t_cmd w_head;
    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;

    ulf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_s_data  (i_s_axis_tdata),
        .i_s_last  (i_s_axis_tlast),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd),
        .i_q_full  (w_full)
    );

    ulf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    ulf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (w_head),
        .i_empty   (w_empty),
        .o_pop     (w_pop),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_m_data  (o_m_axis_tdata),
        .o_m_last  (o_m_axis_tlast)
    );

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("command pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("command popped from an empty queue");

    // The closing beat of an input is never a lead byte or a pair's first half.
    a_last_not_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (o_m_axis_tdata[7:6] != 2'b11))
        else $error("closing beat carries a lead byte");
`endif

endmodule

@@ tb/utf8_latin1_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_latin1_checker
// Watches both stream channels of the UTF-8 validator, predicts the output
// bytes of every accepted input beat and compares each accepted output beat
// against the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_latin1_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    input  logic       i_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,
    input  logic       i_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    input  logic [7:0] i_m_axis_tdata,   // [7:0] out_byte
    input  logic       i_m_axis_tlast,
    output int         o_errors,
    output int         o_pending,
    output int         o_checked
);

    localparam logic [7:0] TOP_BIT   = 8'h80;
    localparam logic [7:0] LEAD2_MSK = 8'hE0;
    localparam logic [7:0] LEAD2_VAL = 8'hC0;
    localparam logic [7:0] LEAD3_MSK = 8'hF0;
    localparam logic [7:0] LEAD3_VAL = 8'hE0;
    localparam logic [7:0] LEAD4_MSK = 8'hF8;
    localparam logic [7:0] LEAD4_VAL = 8'hF0;
    localparam logic [7:0] CONT_MSK  = 8'hC0;
    localparam logic [7:0] CONT_VAL  = 8'h80;
    localparam logic [7:0] LOW6_MSK  = 8'h3F;
    localparam int         MAX_OUT   = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_utf8_beat;

    t_utf8_beat utf8_expected_q[$];

    // Pending run as the block should hold it.
    logic [7:0] run_lead;
    logic [7:0] run_cont [2];
    logic [1:0] run_have;
    logic [1:0] run_need;

    logic [7:0] beat_bytes [MAX_OUT];
    int         beat_count;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        o_errors++;
    endtask

    function automatic void put_byte(input logic [7:0] b);
        if (beat_count < MAX_OUT) begin
            beat_bytes[beat_count] = b;
            beat_count++;
        end
    endfunction

    function automatic void put_latin1(input logic [7:0] b);
        put_byte(LEAD2_VAL | {6'b0, b[7:6]});
        put_byte(CONT_VAL | (b & LOW6_MSK));
    endfunction

    function automatic void drop_run();
        run_lead = '0;
        run_have = '0;
        run_need = '0;
    endfunction

    function automatic void flush_run_latin1();
        put_latin1(run_lead);
        for (int k = 0; k < int'(run_have) && k < 2; k++)
            put_latin1(run_cont[k]);
        drop_run();
    endfunction

    function automatic void take_fresh(input logic [7:0] b);
        if ((b & TOP_BIT) == 8'h00) begin
            put_byte(b);
        end else if ((b & LEAD2_MSK) == LEAD2_VAL) begin
            run_lead = b; run_have = 2'd0; run_need = 2'd1;
        end else if ((b & LEAD3_MSK) == LEAD3_VAL) begin
            run_lead = b; run_have = 2'd0; run_need = 2'd2;
        end else if ((b & LEAD4_MSK) == LEAD4_VAL) begin
            run_lead = b; run_have = 2'd0; run_need = 2'd3;
        end else begin
            put_latin1(b);
        end
    endfunction

    function automatic void predict_utf8(input logic [7:0] b, input logic eot);
        t_utf8_beat ob;
        beat_count = 0;
        if (run_need == 2'd0) begin
            take_fresh(b);
        end else if ((b & CONT_MSK) == CONT_VAL) begin
            if (int'(run_have) + 1 >= int'(run_need) || run_have >= 2'd2) begin
                // Run complete: pass it through untouched.
                put_byte(run_lead);
                for (int j = 0; j < int'(run_have) && j < 2; j++)
                    put_byte(run_cont[j]);
                put_byte(b);
                drop_run();
            end else begin
                run_cont[run_have[0]] = b;
                run_have++;
            end
        end else begin
            flush_run_latin1();
            take_fresh(b);
        end
        if (eot && run_need != 2'd0)
            flush_run_latin1();
        for (int k = 0; k < beat_count; k++) begin
            ob.data = beat_bytes[k];
            ob.last = (k == beat_count - 1);
            utf8_expected_q.push_back(ob);
        end
    endfunction

    always @(posedge i_clk) begin
        t_utf8_beat want;
        if (!i_rst_n) begin
            drop_run();
            run_cont[0] = '0;
            run_cont[1] = '0;
            utf8_expected_q.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                predict_utf8(i_s_axis_tdata, i_s_axis_tlast);
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                o_checked++;
                if (utf8_expected_q.size() == 0) begin
                    report_mismatch($sformatf("output beat 0x%02h with nothing expected",
                                              i_m_axis_tdata));
                end else begin
                    want = utf8_expected_q.pop_front();
                    if (i_m_axis_tdata !== want.data)
                        report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                                  i_m_axis_tdata, want.data));
                    if (i_m_axis_tlast !== want.last)
                        report_mismatch($sformatf("last_of_run %b, expected %b (byte 0x%02h)",
                                                  i_m_axis_tlast, want.last, want.data));
                end
            end
        end
        o_pending = utf8_expected_q.size();
    end

endmodule

@@ tb/tb_utf8_validate_latin1_fallback.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_validate_latin1_fallback
// Feeds the validator directed and random text (ASCII, complete and broken
// multi-byte runs, stray bytes, end-of-text cuts) under three stall patterns
// and lets the checker compare every output beat.
// ----------------------------------------------------------------------------
module tb_utf8_validate_latin1_fallback;

    localparam int RANDOM_ITEMS = 132;
    localparam int DRAIN_CYCLES = 16;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic       i_s_axis_tlast = 1'b0;    // end_of_text
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;           // [7:0] out_byte
    logic       o_m_axis_tlast;           // last_of_run

    int errors;
    int pending;
    int checked;
    int tx_idle_pct;
    int rx_idle_pct = 0;
    int beats_sent;
    int eot_sent;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    utf8_validate_latin1_fallback i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    utf8_latin1_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // One input beat: random idle cycles first, then hold until taken.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= eot;
        do @(posedge i_clk); while (!o_s_axis_tready);
        beats_sent++;
        if (eot)
            eot_sent++;
    endtask

    function automatic logic [7:0] rand_cont();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] rand_lead(input int len);
        case (len)
            2: return 8'hC0 | 8'($urandom_range(0, 31));
            3: return 8'hE0 | 8'($urandom_range(0, 15));
            default: return 8'hF0 | 8'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic logic [7:0] rand_non_cont();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b[7:6] == 2'b10);
        return b;
    endfunction

    function automatic logic rare_eot();
        return ($urandom_range(0, 19) == 0);
    endfunction

    // One random piece of text, mostly well formed.
    task automatic send_random_piece();
        int kind;
        int len;
        int held;
        kind = $urandom_range(0, 9);
        len  = $urandom_range(2, 4);
        case (kind)
            0, 1, 2: begin
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(0, 127)), rare_eot());
            end
            3, 4, 5: begin
                send_byte(rand_lead(len), rare_eot());
                repeat (len - 1)
                    send_byte(rand_cont(), rare_eot());
            end
            6: begin
                // A run broken before it is complete.
                held = $urandom_range(0, len - 2);
                send_byte(rand_lead(len), 1'b0);
                repeat (held)
                    send_byte(rand_cont(), 1'b0);
                send_byte(rand_non_cont(), rare_eot());
            end
            7: begin
                if ($urandom_range(0, 1))
                    send_byte(rand_cont(), rare_eot());
                else
                    send_byte(8'($urandom_range(8'hF8, 8'hFF)), rare_eot());
            end
            8: begin
                // A run cut short by the end of the text.
                held = $urandom_range(0, len - 2);
                if (held == 0) begin
                    send_byte(rand_lead(len), 1'b1);
                end else begin
                    send_byte(rand_lead(len), 1'b0);
                    repeat (held - 1)
                        send_byte(rand_cont(), 1'b0);
                    send_byte(rand_cont(), 1'b1);
                end
            end
            default: begin
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        endcase
    endtask

    task automatic send_directed();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        // Complete runs of two, three and four bytes.
        send_byte(8'hC3, 1'b0); send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hAC, 1'b0);
        send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0); send_byte(8'h80, 1'b0);
        // Stray continuation and stray high byte.
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF8, 1'b0);
        // Broken runs; the second yields eight output beats.
        send_byte(8'hE0, 1'b0); send_byte(8'h41, 1'b0);
        send_byte(8'hF4, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0); send_byte(8'hFF, 1'b0);
        // End of text with a lead alone, then on a new lead after a broken run.
        send_byte(8'hC2, 1'b1);
        send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0);
        send_byte(8'h80, 1'b0); send_byte(8'hF0, 1'b1);
        // End of text on a completing continuation.
        send_byte(8'hDF, 1'b0); send_byte(8'h80, 1'b1);
    endtask

    initial begin
        int start_beats;
        beats_sent  = 0;
        eot_sent    = 0;
        tx_idle_pct = 8;
        rx_idle_pct <= 73;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 8;  rx_idle_pct <= 73; end
                1: begin tx_idle_pct = 73; rx_idle_pct <= 8;  end
                default: begin tx_idle_pct = 0; rx_idle_pct <= 0; end
            endcase
            start_beats = beats_sent;
            while (beats_sent - start_beats < RANDOM_ITEMS / 3)
                send_random_piece();
        end
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tlast  <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d input beats sent, %0d of them ending the text, %0d %s",
                 beats_sent, eot_sent, checked, "output beats compared.");
        $display("Summary: ASCII, whole and broken runs, stray bytes and cut runs, %s",
                 "three stall patterns.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #2ms;
        $display("Timeout with %0d output beats still expected.", pending);
        $display("TEST FAILED");
        $finish;
    end

endmodule
